FILE: src/evpd_pkg.sv
// evpd_pkg: shared types, codes and constants for the ev pilot / proximity decoder
// used by the controller, datapath and top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package evpd_pkg;

   // field widths
   localparam int RCC_W    = 16;
   localparam int DUTY_W   = 10;
   localparam int ADC_W    = 12;
   localparam int VOLT_W   = 16;
   localparam int MODE_W   = 8;
   localparam int CABLE_W  = 2;
   localparam int AMPS_W   = 11;
   localparam int PSTATE_W = 3;
   localparam int LIMIT_W  = 10;
   localparam int MV_W     = 15;
   localparam int PROD_W   = VOLT_W + LIMIT_W;
   localparam int DIV_STEPS = VOLT_W;
   localparam int CNT_W    = $clog2(DIV_STEPS);

   // stream packing
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;

   // register reset
   localparam logic [MODE_W-1:0] CHARGE_CODE_RST = 8'h0A;

   // cable classes
   localparam logic [CABLE_W-1:0] CABLE_UNPLUGGED = 2'd0;
   localparam logic [CABLE_W-1:0] CABLE_S3_CLOSED = 2'd1;
   localparam logic [CABLE_W-1:0] CABLE_S3_OPEN   = 2'd2;

   // pilot states
   localparam logic [PSTATE_W-1:0] PILOT_A  = 3'd0;
   localparam logic [PSTATE_W-1:0] PILOT_B1 = 3'd1;
   localparam logic [PSTATE_W-1:0] PILOT_B2 = 3'd2;
   localparam logic [PSTATE_W-1:0] PILOT_D  = 3'd4;

   // special current codes
   localparam logic signed [AMPS_W-1:0] AMPS_DIGITAL = -11'sd1;
   localparam logic signed [AMPS_W-1:0] AMPS_ERROR   = -11'sd2;

   // proximity thresholds (ohms) and cable limits (deci-amps)
   localparam logic [RCC_W-1:0] RCC_63A    = 16'd100;
   localparam logic [RCC_W-1:0] RCC_32A    = 16'd220;
   localparam logic [RCC_W-1:0] RCC_16A    = 16'd680;
   localparam logic [RCC_W-1:0] RCC_10A    = 16'd1500;
   localparam logic [RCC_W-1:0] RCC_OPEN_LO = 16'd3300;
   localparam logic [RCC_W-1:0] RCC_OPEN_HI = 16'd3520;
   localparam logic [LIMIT_W-1:0] LIM_63A = 10'd630;
   localparam logic [LIMIT_W-1:0] LIM_32A = 10'd320;
   localparam logic [LIMIT_W-1:0] LIM_16A = 10'd160;
   localparam logic [LIMIT_W-1:0] LIM_10A = 10'd100;

   // duty breakpoints (per-mille)
   localparam logic [DUTY_W-1:0] DUTY_ERR_LO  = 10'd30;
   localparam logic [DUTY_W-1:0] DUTY_DIG_HI  = 10'd70;
   localparam logic [DUTY_W-1:0] DUTY_ERR_MID = 10'd80;
   localparam logic [DUTY_W-1:0] DUTY_FIX_HI  = 10'd100;
   localparam logic [DUTY_W-1:0] DUTY_LIN_HI  = 10'd850;
   localparam logic [DUTY_W-1:0] DUTY_HI_OFS  = 10'd640;
   localparam logic [DUTY_W-1:0] DUTY_HI_END  = 10'd960;
   localparam logic [DUTY_W-1:0] DUTY_MAX_END = 10'd970;
   localparam logic signed [AMPS_W-1:0] AMPS_MIN = 11'sd60;
   localparam logic signed [AMPS_W-1:0] AMPS_MAX = 11'sd800;
   // 0.6 in Q16, exact for duty below 850 after floor
   localparam logic [15:0] SIXTENTHS_Q16 = 16'd39324;

   // pilot voltage scale 5.4433 in Q16 and bands in millivolts
   localparam logic [18:0] VCP_SCALE_Q16 = 19'd356732;
   localparam logic [MV_W-1:0] MV_A_HI  = 15'd1000;
   localparam logic [MV_W-1:0] MV_D_LO  = 15'd2000;
   localparam logic [MV_W-1:0] MV_D_HI  = 15'd4000;
   localparam logic [MV_W-1:0] MV_6V_LO = 15'd5000;
   localparam logic [MV_W-1:0] MV_6V_HI = 15'd7000;
   localparam logic [MV_W-1:0] MV_B_LO  = 15'd8000;
   localparam logic [MV_W-1:0] MV_B_HI  = 15'd10000;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_LIMIT,
      ST_PRODUCT,
      ST_DIVIDE,
      ST_FINISH
   } evpd_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic classify;
      logic limit;
      logic product;
      logic div_step;
      logic out_load;
   } evpd_cmd_type;

endpackage

`default_nettype wire

FILE: src/ev_pilot_proximity_decoder_top.sv
// ev_pilot_proximity_decoder_top: top level joining controller and datapath
// depends on evpd_pkg, evpd_ctrl, evpd_dp
//
//  channel | direction | handshake          | payload
//  req     | in        | req_tvalid/tready  | req_tdata (80 bits)
//  rsp     | out       | rsp_tvalid/tready  | rsp_tdata (48 bits)
//  csr     | in        | csr_wr_en          | csr_wr_data (charge enable code)
//
// each request passes from acceptance to the result register through the
// classify, limit and product steps, 16 restoring divide steps and the output load
// one request is in flight at a time; the next is taken the cycle after the
// result is registered
// the output load waits while an earlier result still stalls on rsp_tready
// synchronous active-high reset; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module ev_pilot_proximity_decoder_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // rcc_ohms, pilot_duty, pilot_adc, grid_volts, out_volts, bms_mode, pad
   input  wire logic [evpd_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // cable_status, pilot_amps, pilot_state, input_limit, output_limit,
   // s2_enable, pad
   output logic [evpd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                             csr_wr_en,
   input  wire logic [evpd_pkg::MODE_W-1:0]      csr_wr_data
);
   import evpd_pkg::*;

   evpd_cmd_type cmd;

   // sequencer
   evpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath
   evpd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: src/evpd_ctrl.sv
// evpd_ctrl: sequencer for one request through classify, limit, product and divide
// depends on evpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module evpd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output evpd_pkg::evpd_cmd_type    cmd
);
   import evpd_pkg::*;

   evpd_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;

   // state, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      req_tready = 1'b0;
      valid_in = valid_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            state_in = ST_PRODUCT;
         end
         ST_PRODUCT: begin
            cmd.product = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = valid_ff;

endmodule

`default_nettype wire

FILE: src/evpd_dp.sv
// evpd_dp: decoder datapath with cable, duty and pilot decode, limit state,
// restoring divider and output register; depends on evpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module evpd_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire evpd_pkg::evpd_cmd_type             cmd,
   input  wire logic [evpd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                               csr_wr_en,
   input  wire logic [evpd_pkg::MODE_W-1:0]        csr_wr_data,
   output logic [evpd_pkg::RSP_DATA_W-1:0]         rsp_tdata
);
   import evpd_pkg::*;

   // captured request
   logic [RCC_W-1:0]  rcc_ff;
   logic [DUTY_W-1:0] duty_ff;
   logic [ADC_W-1:0]  adc_ff;
   logic [VOLT_W-1:0] grid_ff;
   logic [VOLT_W-1:0] vout_ff;
   logic [MODE_W-1:0] mode_ff;

   // persistent state
   logic [MODE_W-1:0]   charge_code_ff;
   logic [LIMIT_W-1:0]  cable_limit_ff, cable_limit_in;
   logic [PSTATE_W-1:0] pstate_ff, pstate_in;
   logic                s2_ff;

   // per-request intermediates
   logic [CABLE_W-1:0]       cable_ff, cable_in;
   logic signed [AMPS_W-1:0] amps_ff, amps_in;
   logic [MV_W-1:0]          mv_ff;
   logic signed [AMPS_W-1:0] inlim_ff, inlim_in;
   logic [VOLT_W-1:0]        rem_ff, quo_ff;
   logic                     ovf_ff;
   logic [RSP_DATA_W-1:0]    rsp_ff;

   logic [25:0]       duty_prod;
   logic [9:0]        duty_hi;
   logic [10:0]       duty_x5;
   logic [30:0]       mv_prod;
   logic [LIMIT_W-1:0] inlim_pos;
   logic [PROD_W-1:0] prod;
   logic [VOLT_W:0]   trial;
   logic [VOLT_W:0]   trial_sub;
   logic [VOLT_W-1:0] olim;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rcc_ff  <= req_tdata[15:0];
         duty_ff <= req_tdata[25:16];
         adc_ff  <= req_tdata[37:26];
         grid_ff <= req_tdata[53:38];
         vout_ff <= req_tdata[69:54];
         mode_ff <= req_tdata[77:70];
      end
   end

   // cable class and latched cable limit
   always_comb begin
      cable_in       = CABLE_UNPLUGGED;
      cable_limit_in = cable_limit_ff;
      if (rcc_ff < RCC_10A) begin
         cable_in = CABLE_S3_CLOSED;
         if (rcc_ff < RCC_63A) begin
            cable_limit_in = LIM_63A;
         end else if (rcc_ff < RCC_32A) begin
            cable_limit_in = LIM_32A;
         end else if (rcc_ff < RCC_16A) begin
            cable_limit_in = LIM_16A;
         end else begin
            cable_limit_in = LIM_10A;
         end
      end else if (rcc_ff >= RCC_OPEN_LO && rcc_ff <= RCC_OPEN_HI) begin
         cable_in = CABLE_S3_OPEN;
      end
   end

   // duty to deci-amps
   assign duty_prod = 26'(duty_ff) * 26'(SIXTENTHS_Q16);
   assign duty_hi   = duty_ff - DUTY_HI_OFS;
   assign duty_x5   = {duty_hi[8:0], 2'b00} + {2'b00, duty_hi[8:0]};

   always_comb begin
      if (duty_ff < DUTY_ERR_LO) begin
         amps_in = AMPS_ERROR;
      end else if (duty_ff < DUTY_DIG_HI) begin
         amps_in = AMPS_DIGITAL;
      end else if (duty_ff < DUTY_ERR_MID) begin
         amps_in = AMPS_ERROR;
      end else if (duty_ff < DUTY_FIX_HI) begin
         amps_in = AMPS_MIN;
      end else if (duty_ff < DUTY_LIN_HI) begin
         amps_in = $signed({1'b0, duty_prod[25:16]});
      end else if (duty_ff < DUTY_HI_END) begin
         amps_in = $signed({1'b0, duty_x5[10:1]});
      end else if (duty_ff < DUTY_MAX_END) begin
         amps_in = AMPS_MAX;
      end else begin
         amps_in = AMPS_ERROR;
      end
   end

   // pilot voltage in millivolts
   assign mv_prod = 31'(adc_ff) * 31'(VCP_SCALE_Q16);

   // pilot state from the voltage bands, other levels hold
   always_comb begin
      pstate_in = pstate_ff;
      if (mv_ff <= MV_A_HI) begin
         pstate_in = PILOT_A;
      end else if (mv_ff >= MV_B_LO && mv_ff <= MV_B_HI) begin
         pstate_in = (cable_ff == CABLE_S3_CLOSED) ? PILOT_B2 : PILOT_B1;
      end else if (mv_ff >= MV_6V_LO && mv_ff <= MV_6V_HI) begin
         pstate_in = pstate_ff;
      end else if (mv_ff >= MV_D_LO && mv_ff <= MV_D_HI) begin
         pstate_in = PILOT_D;
      end
   end

   // input limit is the smaller of cable and pilot current
   assign inlim_in = ($signed({1'b0, cable_limit_ff}) < amps_ff) ?
                     $signed({1'b0, cable_limit_ff}) : amps_ff;

   // product of grid volts and the clamped limit
   assign inlim_pos = (inlim_ff > 11'sd0) ? inlim_ff[LIMIT_W-1:0] : '0;
   assign prod      = PROD_W'(grid_ff) * PROD_W'(inlim_pos);

   // one restoring divide step
   assign trial     = {rem_ff, quo_ff[VOLT_W-1]};
   assign trial_sub = trial - {1'b0, vout_ff};

   // persistent state and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         charge_code_ff <= CHARGE_CODE_RST;
         cable_limit_ff <= '0;
         pstate_ff      <= PILOT_A;
         s2_ff          <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            charge_code_ff <= csr_wr_data;
         end
         if (cmd.classify) begin
            cable_limit_ff <= cable_limit_in;
         end
         if (cmd.limit) begin
            pstate_ff <= pstate_in;
            if (pstate_in == PILOT_B2 && mode_ff == charge_code_ff) begin
               s2_ff <= 1'b1;
            end
         end
      end
   end

   // per-request working registers
   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         cable_ff <= cable_in;
         amps_ff  <= amps_in;
         mv_ff    <= mv_prod[30:16];
      end
      if (cmd.limit) begin
         inlim_ff <= inlim_in;
      end
      if (cmd.product) begin
         rem_ff <= VOLT_W'(prod[PROD_W-1:VOLT_W]);
         quo_ff <= prod[VOLT_W-1:0];
         ovf_ff <= VOLT_W'(prod[PROD_W-1:VOLT_W]) >= vout_ff;
      end else if (cmd.div_step) begin
         if (!trial_sub[VOLT_W]) begin
            rem_ff <= trial_sub[VOLT_W-1:0];
            quo_ff <= {quo_ff[VOLT_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[VOLT_W-1:0];
            quo_ff <= {quo_ff[VOLT_W-2:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         rsp_ff <= {4'b0, s2_ff, olim, inlim_ff, pstate_ff, amps_ff, cable_ff};
      end
   end

   // zero divisor gives zero, overflow saturates
   assign olim = (vout_ff == '0) ? '0 : (ovf_ff ? '1 : quo_ff);

   assign rsp_tdata = rsp_ff;

endmodule

`default_nettype wire

FILE: src/evpd_checker.sv
// evpd_checker: port-level assertions for the decoder top, bound to it below
// depends on evpd_pkg and ev_pilot_proximity_decoder_top
`timescale 1ns / 1ps
`default_nettype none

module evpd_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [evpd_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import evpd_pkg::*;

   logic s2_seen_ff;

   // remember that a delivered result already had s2 closed
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[43]) begin
         s2_seen_ff <= 1'b1;
      end
   end

   // stalled result keeps its valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // s2 close stays latched across results
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && s2_seen_ff |-> rsp_tdata[43])
      else $error("s2_enable cleared after being set");

   // pilot state is one of A, B1, B2, D
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:13] == PILOT_A || rsp_tdata[15:13] == PILOT_B1 ||
                      rsp_tdata[15:13] == PILOT_B2 || rsp_tdata[15:13] == PILOT_D))
      else $error("illegal pilot_state");

   // a nonzero output limit needs a positive input limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[42:27] != 16'd0) |->
         !rsp_tdata[26] && (rsp_tdata[25:16] != 10'd0))
      else $error("output_limit without positive input_limit");

   // no request taken while the previous one is still being computed
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during computation");

endmodule

bind ev_pilot_proximity_decoder_top evpd_checker u_evpd_checker (.*);

`default_nettype wire
